### src/sdff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdff_pkg: shared types and constants of the signed decimal field formatter
// Holds the controller states, the command and status groups that join the
// controller to the datapath, and the ASCII codes that the field uses.
// ----------------------------------------------------------------------------
package sdff_pkg;

	// Fixed widths of the transaction fields.
	localparam int MAG_W      = 64;
	localparam int CNT_W      = 6;
	localparam int CHAR_W     = 8;
	localparam int IN_DATA_W  = 80;
	// 2**64 is below 10**20, so twenty decimal digits hold any magnitude.
	localparam int BCD_DIGITS = 20;
	localparam int DIG_IDX_W  = 5;

	// ASCII codes.
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_COUNT,
		ST_PLAN,
		ST_FIRST,
		ST_SPACE,
		ST_SIGN_A,
		ST_LPAD,
		ST_SIGN_B,
		ST_ZEXT,
		ST_DIGIT,
		ST_TPAD
	} state_t;

	// Source of the character that an emit step produces.
	typedef enum logic [2:0] {
		SEL_SPACE,
		SEL_SIGN,
		SEL_FILL,
		SEL_ZERO,
		SEL_DIGIT,
		SEL_TRAIL
	} char_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      conv;
		logic      count;
		logic      plan;
		logic      emit;
		char_sel_t sel;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic conv_last;
		logic space_en;
		logic sign_a_en;
		logic sign_b_en;
		logic lpad_nz;
		logic tpad_nz;
		logic pad_one;
		logic zext_nz;
		logic zext_one;
		logic digit_last;
	} dp_status_t;

endpackage

### src/sdff_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdff_ctrl: sequencing state machine of the field formatter
// Steps one value through capture, conversion, planning and the emission
// phases of the field, and tells the datapath what to do in each cycle.
// ----------------------------------------------------------------------------
module sdff_ctrl
	import sdff_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	// Next phase that has something to emit, looking forward from each point.
	state_t to_digit;
	state_t to_sign_b;
	state_t to_lpad;
	state_t to_sign_a;
	state_t to_space;
	state_t after_digit;

	assign to_digit    = status.zext_nz ? ST_ZEXT : ST_DIGIT;
	assign to_sign_b   = status.sign_b_en ? ST_SIGN_B : to_digit;
	assign to_lpad     = status.lpad_nz ? ST_LPAD : to_sign_b;
	assign to_sign_a   = status.sign_a_en ? ST_SIGN_A : to_lpad;
	assign to_space    = status.space_en ? ST_SPACE : to_sign_a;
	assign after_digit = status.tpad_nz ? ST_TPAD : ST_IDLE;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.sel  = SEL_SPACE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				if (status.conv_last) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = ST_PLAN;
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = ST_FIRST;
			end
			ST_FIRST: begin
				state_d = to_space;
			end
			ST_SPACE: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_SPACE;
				if (status.out_free) begin
					state_d = to_sign_a;
				end
			end
			ST_SIGN_A: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_SIGN;
				if (status.out_free) begin
					state_d = to_lpad;
				end
			end
			ST_LPAD: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_FILL;
				if (status.out_free && status.pad_one) begin
					state_d = to_sign_b;
				end
			end
			ST_SIGN_B: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_SIGN;
				if (status.out_free) begin
					state_d = to_digit;
				end
			end
			ST_ZEXT: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_ZERO;
				if (status.out_free && status.zext_one) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_DIGIT;
				if (status.out_free && status.digit_last) begin
					state_d = after_digit;
				end
			end
			ST_TPAD: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_TRAIL;
				if (status.out_free && status.pad_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### src/sdff_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdff_dp: datapath of the field formatter
// Holds the captured value and flags, converts the magnitude to BCD one bit
// per cycle, plans the field layout and drives the output register.
// ----------------------------------------------------------------------------
module sdff_dp
	import sdff_pkg::*;
#(
	parameter int FIELD_LIMIT = 62,
	parameter int DIGIT_STORE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  logic [MAG_W-1:0]     value,
	input  logic [CNT_W-1:0]     field_width,
	input  logic [CNT_W-1:0]     min_digits,
	input  logic                 align_left,
	input  logic                 zero_fill,
	input  logic                 force_plus,
	input  logic                 space_flag,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHAR_W-1:0]    out_char,
	output logic                 last_char
);

	// Precision is capped by the field limit and by the digit store.
	localparam int PREC_CAP = (FIELD_LIMIT - 1 < DIGIT_STORE) ? FIELD_LIMIT - 1 : DIGIT_STORE;
	localparam logic [CNT_W-1:0] PREC_CAP_V  = CNT_W'(PREC_CAP);
	localparam logic [CNT_W-1:0] WIDTH_CAP_V = CNT_W'(FIELD_LIMIT);
	localparam logic [CNT_W-1:0] CONV_LAST_V = CNT_W'(MAG_W - 1);

	// Captured operand and flags.
	logic [MAG_W-1:0]     mag_q;
	logic                 neg_q;
	logic [CNT_W-1:0]     width_q;
	logic [CNT_W-1:0]     prec_q;
	logic                 left_q;
	logic                 zfill_q;
	logic                 plus_q;
	logic                 space_q;

	// Conversion and layout registers.
	logic [3:0]           bcd_q [BCD_DIGITS];
	logic [3:0]           bcd_d [BCD_DIGITS];
	logic [CNT_W-1:0]     conv_cnt_q;
	logic [DIG_IDX_W-1:0] ndig_q;
	logic [DIG_IDX_W-1:0] ndig_d;
	logic [DIG_IDX_W-1:0] dig_idx_q;
	logic [CNT_W-1:0]     zext_q;
	logic [CNT_W-1:0]     pad_q;
	logic [CNT_W-1:0]     total_q;

	// Output register.
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 out_last_q;

	logic                 has_sign;
	logic                 lead_space;
	logic [CNT_W-1:0]     ndig_ext;
	logic [CNT_W-1:0]     len;
	logic [CNT_W-1:0]     pad_d;
	logic [CNT_W-1:0]     total_d;
	logic                 out_free;
	logic                 step;
	logic [CHAR_W-1:0]    sign_char;
	logic [CHAR_W-1:0]    next_char;

	assign has_sign   = neg_q | plus_q;
	assign lead_space = space_q & ~neg_q;
	assign sign_char  = neg_q ? CH_MINUS : CH_PLUS;
	assign out_free   = ~out_valid_q | out_ready;
	assign step       = cmd.emit & out_free;

	// Shift-and-add-3 step: every digit of 5 or more is corrected, then the
	// whole BCD word shifts left by one and takes the next magnitude bit.
	always_comb begin
		logic [3:0] adj [BCD_DIGITS];
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (i == 0) begin
				bcd_d[i] = {adj[i][2:0], mag_q[MAG_W-1]};
			end else begin
				bcd_d[i] = {adj[i][2:0], adj[i-1][3]};
			end
		end
	end

	// Significant digit count: one past the highest nonzero digit, at least one.
	always_comb begin
		ndig_d = DIG_IDX_W'(1);
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) begin
				ndig_d = DIG_IDX_W'(i + 1);
			end
		end
	end

	// Layout of the field: digit count with zero extension, then padding.
	always_comb begin
		ndig_ext = CNT_W'(ndig_q);
		len      = (ndig_ext > prec_q) ? ndig_ext : prec_q;
		pad_d    = (width_q > len) ? (width_q - len - CNT_W'(has_sign)) : '0;
		total_d  = CNT_W'(lead_space) + CNT_W'(has_sign) + pad_d + len;
	end

	// Character for the current emit step.
	always_comb begin
		case (cmd.sel)
			SEL_SPACE: next_char = CH_SPACE;
			SEL_SIGN:  next_char = sign_char;
			SEL_FILL:  next_char = zfill_q ? CH_ZERO : CH_SPACE;
			SEL_ZERO:  next_char = CH_ZERO;
			SEL_DIGIT: next_char = CH_ZERO + {4'd0, bcd_q[dig_idx_q]};
			SEL_TRAIL: next_char = CH_SPACE;
			default:   next_char = CH_SPACE;
		endcase
	end

	// Operand capture, conversion and planning.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q   <= value[MAG_W-1];
			mag_q   <= value[MAG_W-1] ? (~value + MAG_W'(1)) : value;
			width_q <= (field_width > WIDTH_CAP_V) ? WIDTH_CAP_V : field_width;
			prec_q  <= (min_digits > PREC_CAP_V) ? PREC_CAP_V : min_digits;
			left_q  <= align_left;
			zfill_q <= zero_fill;
			plus_q  <= force_plus;
			space_q <= space_flag;
			for (int i = 0; i < BCD_DIGITS; i++) begin
				bcd_q[i] <= 4'd0;
			end
		end else if (cmd.conv) begin
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
			for (int i = 0; i < BCD_DIGITS; i++) begin
				bcd_q[i] <= bcd_d[i];
			end
		end
		if (cmd.count) begin
			ndig_q <= ndig_d;
		end
		if (cmd.plan) begin
			zext_q    <= len - ndig_ext;
			pad_q     <= pad_d;
			total_q   <= total_d;
			dig_idx_q <= ndig_q - DIG_IDX_W'(1);
		end else if (step) begin
			total_q <= total_q - CNT_W'(1);
			case (cmd.sel)
				SEL_FILL, SEL_TRAIL: pad_q     <= pad_q - CNT_W'(1);
				SEL_ZERO:            zext_q    <= zext_q - CNT_W'(1);
				SEL_DIGIT:           dig_idx_q <= dig_idx_q - DIG_IDX_W'(1);
				default:             ;
			endcase
		end
	end

	// Conversion bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_cnt_q <= '0;
		end else if (cmd.load) begin
			conv_cnt_q <= '0;
		end else if (cmd.conv) begin
			conv_cnt_q <= conv_cnt_q + CNT_W'(1);
		end
	end

	// Output register: loads on an emit step, empties when the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_char_q <= next_char;
			out_last_q <= (total_q == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = out_last_q;

	// Status toward the controller.
	always_comb begin
		status            = '0;
		status.out_free   = out_free;
		status.conv_last  = (conv_cnt_q == CONV_LAST_V);
		status.space_en   = lead_space;
		status.sign_a_en  = has_sign & zfill_q;
		status.sign_b_en  = has_sign & ~zfill_q;
		status.lpad_nz    = ~left_q & (pad_q != '0);
		status.tpad_nz    = left_q & (pad_q != '0);
		status.pad_one    = (pad_q == CNT_W'(1));
		status.zext_nz    = (zext_q != '0);
		status.zext_one   = (zext_q == CNT_W'(1));
		status.digit_last = (dig_idx_q == '0);
	end

endmodule

### src/signed_decimal_field_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter: printf-style %d field generator
// Takes one signed 64-bit value with width, precision and flag settings and
// streams out the ASCII characters of its formatted field, last one marked.
// ----------------------------------------------------------------------------
// One value is handled at a time. After the accepting cycle, a shift-and-add-3
// binary to BCD converter runs over all 64 bits of the magnitude, the states
// ST_COUNT, ST_PLAN and ST_FIRST count the digits and lay out the field, and
// then one character leaves per cycle while the output is not stalled. A
// field holds 1 to 63 characters. The conversion loop sets the floor on the
// time from one accepted value to the next. The next value is accepted as
// soon as the last character of a field sits in the output register, even
// while that character still waits to be taken.
module signed_decimal_field_formatter
	import sdff_pkg::*;
#(
	parameter int FIELD_LIMIT = 62,
	parameter int DIGIT_STORE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input transactions.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// Fields from bit 0 up: value[63:0], field_width[69:64], min_digits[75:70],
	// align_left[76], zero_fill[77], force_plus[78], space_flag[79].
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	// Output transactions.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// Fields from bit 0 up: out_char[7:0].
	output logic [CHAR_W-1:0]    m_axis_tdata,
	// Marks the last character of a field (last_char).
	output logic                 m_axis_tlast
);

	dp_cmd_t    cmd;
	dp_status_t status;

	sdff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sdff_dp #(
		.FIELD_LIMIT (FIELD_LIMIT),
		.DIGIT_STORE (DIGIT_STORE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.value       (s_axis_tdata[63:0]),
		.field_width (s_axis_tdata[69:64]),
		.min_digits  (s_axis_tdata[75:70]),
		.align_left  (s_axis_tdata[76]),
		.zero_fill   (s_axis_tdata[77]),
		.force_plus  (s_axis_tdata[78]),
		.space_flag  (s_axis_tdata[79]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_char    (m_axis_tdata),
		.last_char   (m_axis_tlast)
	);

endmodule

### src/sdff_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdff_chk: port checker of the field formatter
// Watches the top-level ports for stream rules and for the character set
// and sequencing that the formatter guarantees.
// ----------------------------------------------------------------------------
module sdff_chk
	import sdff_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [IN_DATA_W-1:0] s_axis_tdata,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [CHAR_W-1:0]    m_axis_tdata,
	input logic                 m_axis_tlast
);

	// A waiting input transaction keeps its fields until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata))
		else $error("input transaction changed while waiting");

	// A stalled output transaction holds its character and marker.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output transaction changed while stalled");

	// Only digits, space, plus and minus ever leave the block.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata >= CH_ZERO && m_axis_tdata <= CH_ZERO + 8'd9) ||
			m_axis_tdata == CH_SPACE || m_axis_tdata == CH_PLUS ||
			m_axis_tdata == CH_MINUS)
		else $error("output character outside the field alphabet");

	// One value at a time: after an input transaction the block is busy.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a value is in progress");

	// While the block is ready for a value, a pending character must end a field.
	a_idle_tail: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
		else $error("ready for a new value in the middle of a field");

endmodule

bind signed_decimal_field_formatter sdff_chk u_sdff_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
